### sv/lruc_pkg.sv
// ----------------------------------------------------------------------------
// lruc_pkg: shared types and constants of the two-way LRU cache tag engine
// Field widths, register indexes, reset costs and the payload structs.
// ----------------------------------------------------------------------------
package lruc_pkg;

  localparam int ADDR_W      = 20;
  localparam int VTAG_W      = 11;
  localparam int COST_W      = 11;
  localparam int HIT_COST_W  = 8;
  localparam int FILL_COST_W = 10;
  localparam int WB_COST_W   = 10;
  localparam int TOTAL_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  // Default geometry: 16 sets, 32-byte lines, 11-bit tags
  localparam int DEF_SET_BITS    = 4;
  localparam int DEF_OFFSET_BITS = 5;
  localparam int DEF_TAG_BITS    = 11;

  // Queue between classification and accounting
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIT_COST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WB_COST   = 2'd2;

  localparam logic [HIT_COST_W-1:0]  HIT_COST_RST  = 8'd6;
  localparam logic [FILL_COST_W-1:0] FILL_COST_RST = 10'd120;
  localparam logic [WB_COST_W-1:0]   WB_COST_RST   = 10'd116;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               way_used;
    logic               writeback;
    logic [VTAG_W-1:0]  victim_tag;
    logic [COST_W-1:0]  access_cycles;
    logic [TOTAL_W-1:0] total_cycles;
    logic [TOTAL_W-1:0] hit_count;
    logic [TOTAL_W-1:0] miss_count;
  } out_item_t;

  // Outcome of one lookup, handed from the front to the back
  typedef struct packed {
    logic              hit;
    logic              way_used;
    logic              writeback;
    logic [VTAG_W-1:0] victim_tag;
  } cls_t;

endpackage

### sv/two_way_lru_writeback_cache_tags.sv
// ----------------------------------------------------------------------------
// two_way_lru_writeback_cache_tags: 2-way set-associative write-back tag engine
// LRU replacement, dirty-victim detection, per-access cost and saturating totals.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one read or write access per transfer (command, byte address).
//   out_*  : one result per access, in order: hit, way used, write-back flag
//            with the dirty victim's tag, cost of the access and the running
//            cycle, hit and miss totals after it.
//   cfg_*  : register writes (0 hit cost, 1 fill cost, 2 write-back cost);
//            always ready, other indexes are ignored. Write only while idle.
// Path: set RAM read, lookup, outcome queue, then the registered result.
// Accesses: each access reads its set entry from the set RAM and writes it back
//   on the next cycle, and the next access waits for that write, so a new
//   access is taken only after the previous one has left the lookup.
// Reset: costs return to 6/120/116 and totals to zero. A clearing pass then
//   zeroes all 2**SET_BITS sets of the set RAM (16 by default), one set per
//   cycle; in_ready stays low until it finishes.
// Stall: a stalled result holds in the output register while a two-entry
//   queue takes further outcomes; in_ready drops once that queue is full.
// ----------------------------------------------------------------------------
module two_way_lru_writeback_cache_tags import lruc_pkg::*; #(
  parameter int SET_BITS    = DEF_SET_BITS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Outcome path: front -> queue -> back
  logic push, q_full, q_valid, q_pop;
  cls_t push_data, q_data;

  // Lookup, LRU update and victim selection
  lruc_front #(
    .SET_BITS    (SET_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Hold outcomes while the result side is stalled
  lruc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop)
  );

  // Charge costs, advance totals, drive the result register
  lruc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### sv/lruc_ram.sv
// ----------------------------------------------------------------------------
// lruc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lruc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/lruc_front.sv
// ----------------------------------------------------------------------------
// lruc_front: lookup and replacement front end
// Clears the set RAM after reset, then reads a set per access, compares
// both ways, writes back the updated set entry and queues the outcome.
// ----------------------------------------------------------------------------
module lruc_front import lruc_pkg::*; #(
  parameter int SET_BITS    = DEF_SET_BITS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     push,
  output cls_t     push_data,
  input  logic     q_full
);

  localparam int SET_COUNT = 1 << SET_BITS;
  localparam int LINE_W    = ADDR_W - OFFSET_BITS;
  localparam int ENTRY_W   = 2 * TAG_BITS + 5;
  // Set entry layout
  localparam int E_LRU  = 0;
  localparam int E_V0   = 1;
  localparam int E_V1   = 2;
  localparam int E_D0   = 3;
  localparam int E_D1   = 4;
  localparam int E_TAG0 = 5;
  localparam int E_TAG1 = 5 + TAG_BITS;

  localparam logic [1:0] F_CLEAR = 2'd0;
  localparam logic [1:0] F_IDLE  = 2'd1;
  localparam logic [1:0] F_LOOK  = 2'd2;

  logic [1:0]          st_r, st_nxt;
  logic [SET_BITS-1:0] clr_idx_r;
  logic                cmd_r;
  logic [SET_BITS-1:0] set_r;
  logic [TAG_BITS-1:0] tag_r;

  logic [LINE_W-1:0]          line;
  logic [LINE_W+TAG_BITS-1:0] line_ext;
  logic [SET_BITS-1:0]        in_set;
  logic [TAG_BITS-1:0]        in_tag;
  logic                       accept;

  logic                ram_we;
  logic [SET_BITS-1:0] ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  rd;
  logic [ENTRY_W-1:0]  upd;

  logic                v0, v1, d0, d1, lru;
  logic [TAG_BITS-1:0] t0, t1, vtag;
  logic                hit0, hit1, hit, way, wb;
  logic [TAG_BITS+VTAG_W-1:0] vtag_ext;

  assign line     = in_item.address[ADDR_W-1:OFFSET_BITS];
  assign line_ext = {{TAG_BITS{1'b0}}, line};
  assign in_set   = line[SET_BITS-1:0];
  assign in_tag   = line_ext[SET_BITS +: TAG_BITS];

  assign in_ready = (st_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  lruc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SET_COUNT)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_set),
    .rdata (rd)
  );

  // Decode the set entry read at acceptance
  assign lru = rd[E_LRU];
  assign v0  = rd[E_V0];
  assign v1  = rd[E_V1];
  assign d0  = rd[E_D0];
  assign d1  = rd[E_D1];
  assign t0  = rd[E_TAG0 +: TAG_BITS];
  assign t1  = rd[E_TAG1 +: TAG_BITS];

  // Way 0 wins when both match
  assign hit0 = v0 && (t0 == tag_r);
  assign hit1 = !hit0 && v1 && (t1 == tag_r);
  assign hit  = hit0 || hit1;
  assign way  = hit ? hit1 : lru;
  assign wb   = !hit && (way ? (v1 && d1) : (v0 && d0));
  assign vtag = way ? t1 : t0;
  assign vtag_ext = {{VTAG_W{1'b0}}, vtag};

  always_comb begin
    upd = rd;
    if (hit) begin
      if (cmd_r == CMD_WRITE) begin
        if (way) upd[E_D1] = 1'b1;
        else     upd[E_D0] = 1'b1;
      end
    end else begin
      if (way) begin
        upd[E_TAG1 +: TAG_BITS] = tag_r;
        upd[E_V1]               = 1'b1;
        upd[E_D1]               = cmd_r;
      end else begin
        upd[E_TAG0 +: TAG_BITS] = tag_r;
        upd[E_V0]               = 1'b1;
        upd[E_D0]               = cmd_r;
      end
    end
    upd[E_LRU] = ~way;
  end

  assign ram_we    = (st_r == F_CLEAR) || (st_r == F_LOOK);
  assign ram_waddr = (st_r == F_CLEAR) ? clr_idx_r : set_r;
  assign ram_wdata = (st_r == F_CLEAR) ? '0 : upd;

  assign push                 = (st_r == F_LOOK);
  assign push_data.hit        = hit;
  assign push_data.way_used   = way;
  assign push_data.writeback  = wb;
  assign push_data.victim_tag = wb ? vtag_ext[VTAG_W-1:0] : '0;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_CLEAR: begin
        if (clr_idx_r == '1) st_nxt = F_IDLE;
      end
      F_IDLE: begin
        if (accept) st_nxt = F_LOOK;
      end
      F_LOOK: begin
        st_nxt = F_IDLE;
      end
      default: begin
        st_nxt = F_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= F_CLEAR;
      clr_idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == F_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item.command;
      set_r <= in_set;
      tag_r <= in_tag;
    end
  end

`ifndef SYNTHESIS
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (st_r == F_LOOK))
    else $error("front did not enter lookup after acceptance");
  a_look_once: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_LOOK) |=> (st_r == F_IDLE) && !push)
    else $error("lookup lasted more than one cycle");
  a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_data.writeback) |-> !push_data.hit)
    else $error("write-back flagged on a hit");
`endif

endmodule

### sv/lruc_fifo.sv
// ----------------------------------------------------------------------------
// lruc_fifo: short queue of lookup outcomes
// Decouples the lookup front from the accounting back end.
// ----------------------------------------------------------------------------
module lruc_fifo import lruc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_data,
  output logic full,
  output logic q_valid,
  output cls_t q_data,
  input  logic pop
);

  cls_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("outcome pushed into a full queue");
`endif

endmodule

### sv/lruc_back.sv
// ----------------------------------------------------------------------------
// lruc_back: cost accounting and result register
// Holds the cost registers, charges each outcome and keeps saturating totals.
// ----------------------------------------------------------------------------
module lruc_back import lruc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  cls_t                  q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  logic [HIT_COST_W-1:0]  hit_cost_r;
  logic [FILL_COST_W-1:0] fill_cost_r;
  logic [WB_COST_W-1:0]   wb_cost_r;

  logic [TOTAL_W-1:0] cyc_total_r, cyc_total_nxt;
  logic [TOTAL_W-1:0] hit_total_r, hit_total_nxt;
  logic [TOTAL_W-1:0] miss_total_r, miss_total_nxt;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [COST_W-1:0]  cost;
  logic [TOTAL_W:0]   cyc_sum;

  assign cfg_ready = 1'b1;
  assign q_pop     = q_valid && (!out_valid_r || out_ready);

  assign cost = q_data.hit ? COST_W'(hit_cost_r)
              : COST_W'(fill_cost_r) + (q_data.writeback ? COST_W'(wb_cost_r) : '0);
  assign cyc_sum = {1'b0, cyc_total_r} + (TOTAL_W + 1)'(cost);

  always_comb begin
    cyc_total_nxt  = cyc_sum[TOTAL_W] ? TOTAL_MAX : cyc_sum[TOTAL_W-1:0];
    hit_total_nxt  = hit_total_r;
    miss_total_nxt = miss_total_r;
    if (q_data.hit) begin
      if (hit_total_r != TOTAL_MAX) hit_total_nxt = hit_total_r + 1'b1;
    end else begin
      if (miss_total_r != TOTAL_MAX) miss_total_nxt = miss_total_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cost_r  <= HIT_COST_RST;
      fill_cost_r <= FILL_COST_RST;
      wb_cost_r   <= WB_COST_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIT_COST:  hit_cost_r  <= cfg_data[HIT_COST_W-1:0];
        REG_FILL_COST: fill_cost_r <= cfg_data[FILL_COST_W-1:0];
        REG_WB_COST:   wb_cost_r   <= cfg_data[WB_COST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_total_r  <= '0;
      hit_total_r  <= '0;
      miss_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        cyc_total_r  <= cyc_total_nxt;
        hit_total_r  <= hit_total_nxt;
        miss_total_r <= miss_total_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item_r.hit           <= q_data.hit;
      out_item_r.way_used      <= q_data.way_used;
      out_item_r.writeback     <= q_data.writeback;
      out_item_r.victim_tag    <= q_data.victim_tag;
      out_item_r.access_cycles <= cost;
      out_item_r.total_cycles  <= cyc_total_nxt;
      out_item_r.hit_count     <= hit_total_nxt;
      out_item_r.miss_count    <= miss_total_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop |=> $stable(cyc_total_r) && $stable(hit_total_r) && $stable(miss_total_r))
    else $error("totals moved without a charged access");
`endif

endmodule
